FILE: rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg: shared types and constants for the keypad scanner
// Field widths, scan phase codes, reset values and the fixed key map.
// ----------------------------------------------------------------------------
package kse_pkg;

   localparam int unsigned ColWidth      = 4;
   localparam int unsigned RowWidth      = 4;
   localparam int unsigned KeyWidth      = 6;
   localparam int unsigned NumberWidth   = 32;
   localparam int unsigned DebounceWidth = 24;
   localparam int unsigned RowIdxWidth   = 3;

   localparam logic [DebounceWidth-1:0] DebounceReset = 24'd170;
   localparam logic [KeyWidth-1:0]      LastDigit     = 6'd9;
   localparam logic [ColWidth-1:0]      ColsIdle      = 4'hF;

   // scan phases, one-hot
   typedef enum logic [3:0] {
      PH_IDLE     = 4'b0001,
      PH_SCAN     = 4'b0010,
      PH_RELEASE  = 4'b0100,
      PH_DEBOUNCE = 4'b1000
   } phase_type;

   // fixed key map: row-major, 4 rows by 4 columns
   function automatic logic [KeyWidth-1:0] key_lookup(input logic [1:0] row,
                                                     input logic [1:0] col);
      logic [KeyWidth-1:0] code;
      unique case ({row, col})
         4'h0:    code = 6'd1;
         4'h1:    code = 6'd2;
         4'h2:    code = 6'd3;
         4'h3:    code = 6'd4;
         4'h4:    code = 6'd5;
         4'h5:    code = 6'd6;
         4'h6:    code = 6'd7;
         4'h7:    code = 6'd8;
         4'h8:    code = 6'd9;
         4'h9:    code = 6'd10;
         4'hA:    code = 6'd11;
         4'hB:    code = 6'd12;
         4'hC:    code = 6'd13;
         4'hD:    code = 6'd14;
         4'hE:    code = 6'd61;
         default: code = 6'd0;
      endcase
      return code;
   endfunction

endpackage

FILE: rtl/kse_if.sv
// ----------------------------------------------------------------------------
// kse_if: handshake channels of the keypad scanner
// Request (column sample), response (result item) and register write channel.
// ----------------------------------------------------------------------------
interface kse_req_if
   import kse_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [ColWidth-1:0] col_sense;

   modport source (output valid, output col_sense, input ready);
   modport sink   (input valid, input col_sense, output ready);
endinterface

interface kse_rsp_if
   import kse_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [RowWidth-1:0]    row_drive;
   logic                   key_valid;
   logic [KeyWidth-1:0]    key_code;
   logic                   number_valid;
   logic [NumberWidth-1:0] number_value;

   modport source (output valid, output row_drive, output key_valid, output key_code,
                   output number_valid, output number_value, input ready);
   modport sink   (input valid, input row_drive, input key_valid, input key_code,
                   input number_valid, input number_value, output ready);
endinterface

interface kse_csr_if
   import kse_pkg::*;
   ();
   logic                     valid;
   logic                     ready;
   logic [DebounceWidth-1:0] debounce_ticks;

   modport source (output valid, output debounce_ticks, input ready);
   modport sink   (input valid, input debounce_ticks, output ready);
endinterface

FILE: rtl/keypad_scan_number_entry.sv
// Each request transfer loads its response into the output register on the next clock edge.
// Throughput: one tick per cycle; the output register refills in the same cycle it
// drains, so the only limit is the response side's ready.
// Reset (synchronous, active high): phase idle, all scan state and the accumulator
// zero, debounce_ticks back to 170, output register empty.
// ----------------------------------------------------------------------------
// keypad_scan_number_entry: 4x4 matrix keypad scanner with decimal entry
// Each request is one scan tick carrying the sampled column lines; each tick
// yields one response with the row drive for the next tick and any key or
// completed number.
// ----------------------------------------------------------------------------
module keypad_scan_number_entry
   import kse_pkg::*;
   (
   input  logic   clock,
   input  logic   reset,
   kse_req_if.sink   req_if,
   kse_rsp_if.source rsp_if,
   kse_csr_if.sink   csr_if
   );

   // scan state
   phase_type                phase_ff,    phase_in;
   logic [RowIdxWidth-1:0]   row_ff,      row_in;
   logic [KeyWidth-1:0]      held_ff,     held_in;
   logic [DebounceWidth-1:0] count_ff,    count_in;
   logic [NumberWidth-1:0]   acc_ff,      acc_in;
   logic [DebounceWidth-1:0] debounce_ff;

   // output register
   logic                     rsp_valid_ff;
   logic [RowWidth-1:0]      drive_ff,    drive_in;
   logic                     kvalid_ff,   kvalid_in;
   logic [KeyWidth-1:0]      kcode_ff,    kcode_in;
   logic                     nvalid_ff,   nvalid_in;
   logic [NumberWidth-1:0]   nvalue_ff,   nvalue_in;

   logic                     req_xfer;
   logic                     pressed;
   logic [1:0]               low_col;
   logic [RowIdxWidth-1:0]   row_next;
   logic [NumberWidth-1:0]   acc_times_ten;

   // Take a new tick whenever the output register is empty or drains this cycle.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;

   // Register writes are accepted at any time; the host is to write only while idle, which the block does not enforce.
   assign csr_if.ready = 1'b1;

   assign pressed  = (req_if.col_sense != ColsIdle);
   assign row_next = row_ff + RowIdxWidth'(1);

   // acc*10 as two shifted adds
   assign acc_times_ten = {acc_ff[NumberWidth-4:0], 3'b000}
                        + {acc_ff[NumberWidth-2:0], 1'b0};

   // lowest column reading low; column 0 when none
   always_comb begin
      priority if (!req_if.col_sense[0]) low_col = 2'd0;
      else if (!req_if.col_sense[1])     low_col = 2'd1;
      else if (!req_if.col_sense[2])     low_col = 2'd2;
      else if (!req_if.col_sense[3])     low_col = 2'd3;
      else                               low_col = 2'd0;
   end

   // One tick of the scanner. Rows are all grounded (drive 0) unless a row
   // under test is selected for the next tick.
   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      held_in   = held_ff;
      count_in  = count_ff;
      acc_in    = acc_ff;
      drive_in  = '0;
      kvalid_in = 1'b0;
      kcode_in  = '0;
      nvalid_in = 1'b0;
      nvalue_in = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (pressed) begin
               phase_in = PH_SCAN;
               row_in   = '0;
               drive_in = 4'b1110;
            end
         end
         PH_SCAN: begin
            if (row_ff[RowIdxWidth-1]) begin
               // row index out of range: treat as a bounce
               phase_in = PH_IDLE;
               row_in   = '0;
            end else if (pressed) begin
               held_in  = key_lookup(row_ff[1:0], low_col);
               phase_in = PH_RELEASE;
            end else if (row_next[RowIdxWidth-1]) begin
               // all four rows tried, nothing found: bounce
               phase_in = PH_IDLE;
               row_in   = '0;
            end else begin
               row_in   = row_next;
               drive_in = ~(RowWidth'(1) << row_next[1:0]);
            end
         end
         PH_RELEASE: begin
            if (!pressed) begin
               count_in = debounce_ff;
               phase_in = PH_DEBOUNCE;
            end
         end
         PH_DEBOUNCE: begin
            if (count_ff != '0) begin
               count_in = count_ff - DebounceWidth'(1);
            end else begin
               kvalid_in = 1'b1;
               kcode_in  = held_ff;
               if (held_ff <= LastDigit) begin
                  acc_in = acc_times_ten + NumberWidth'(held_ff);
               end else begin
                  // terminator key: report the number and start over
                  nvalid_in = 1'b1;
                  nvalue_in = acc_ff;
                  acc_in    = '0;
               end
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            row_in   = '0;
         end
      endcase
   end

   // scan state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         row_ff      <= '0;
         held_ff     <= '0;
         count_ff    <= '0;
         acc_ff      <= '0;
         debounce_ff <= DebounceReset;
      end else begin
         if (req_xfer) begin
            phase_ff <= phase_in;
            row_ff   <= row_in;
            held_ff  <= held_in;
            count_ff <= count_in;
            acc_ff   <= acc_in;
         end
         if (csr_if.valid && csr_if.ready) begin
            debounce_ff <= csr_if.debounce_ticks;
         end
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload, loaded on every request transfer
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         drive_ff  <= drive_in;
         kvalid_ff <= kvalid_in;
         kcode_ff  <= kcode_in;
         nvalid_ff <= nvalid_in;
         nvalue_ff <= nvalue_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.row_drive    = drive_ff;
   assign rsp_if.key_valid    = kvalid_ff;
   assign rsp_if.key_code     = kcode_ff;
   assign rsp_if.number_valid = nvalid_ff;
   assign rsp_if.number_value = nvalue_ff;

endmodule
